// ----- design/rmm_pkg.sv -----
`timescale 1ns / 1ps

package rmm_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SERVICE = 2'd1,
        OP_RESTORE = 2'd2,
        OP_SET     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_WRITE = 2'd2
    } t_flash_cmd;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SECOND   = 2'd0,
        CFG_SECONDS_PER_MINUTE = 2'd1
    } t_cfg_index;

    localparam logic [7:0]  TPS_RESET   = 8'd100;
    localparam logic [7:0]  SPM_RESET   = 8'd60;
    localparam logic [7:0]  SEC_RESET   = 8'd30;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam int          WORD_BYTES  = 4;

    // result queue push control
    typedef struct packed {
        logic push;
        logic dual;
    } t_push_ctl;

endpackage

// ----- design/rmm_core.sv -----
`timescale 1ns / 1ps

module rmm_core #(
    parameter int PAGE_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  rmm_pkg::t_opcode              i_opcode,
    input  logic [6:0]                    i_word_index,
    input  logic [31:0]                   i_value,
    input  logic [7:0]                    i_ticks_per_second,
    input  logic [7:0]                    i_seconds_per_minute,
    output rmm_pkg::t_push_ctl            o_push,
    output logic [$clog2(PAGE_BYTES)+67:0] o_res_first,
    output logic [$clog2(PAGE_BYTES)+67:0] o_res_second
);

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int LP_W  = OFF_W + 1;
    localparam int WORDS = PAGE_BYTES / rmm_pkg::WORD_BYTES;

    logic [7:0]      r_tick_count,    n_tick_count;
    logic [7:0]      r_second_count,  n_second_count;
    logic            r_minute_pending, n_minute_pending;
    logic [31:0]     r_minute_total,  n_minute_total;
    logic [LP_W-1:0] r_log_pointer,   n_log_pointer;
    logic            r_restore_done,  n_restore_done;

    logic [7:0]          tick_inc;
    logic [7:0]          sec_inc;
    logic [31:0]         total_inc;
    logic [9:0]          idx_bytes;
    logic [9:0]          idx_next_bytes;
    logic                idx_in_page;
    logic                val_erased;

    rmm_pkg::t_flash_cmd cmd0, cmd1;
    logic [OFF_W-1:0]    off0;
    logic [31:0]         data0, data1;
    logic                upd0;
    logic                dual;

    assign tick_inc       = r_tick_count + 8'd1;
    assign sec_inc        = r_second_count + 8'd1;
    assign total_inc      = r_minute_total + 32'd1;
    assign idx_bytes      = {1'b0, i_word_index, 2'b00};
    assign idx_next_bytes = {({1'b0, i_word_index} + 8'd1), 2'b00};
    assign idx_in_page    = 32'(i_word_index) < WORDS;
    assign val_erased     = i_value == rmm_pkg::ERASED_WORD;

    always_comb begin
        n_tick_count     = r_tick_count;
        n_second_count   = r_second_count;
        n_minute_pending = r_minute_pending;
        n_minute_total   = r_minute_total;
        n_log_pointer    = r_log_pointer;
        n_restore_done   = r_restore_done;
        cmd0  = rmm_pkg::CMD_NONE;
        cmd1  = rmm_pkg::CMD_WRITE;
        off0  = '0;
        data0 = '0;
        data1 = '0;
        upd0  = 1'b0;
        dual  = 1'b0;
        unique case (i_opcode)
            rmm_pkg::OP_TICK: begin
                if (tick_inc >= i_ticks_per_second) begin
                    n_tick_count = '0;
                    if (sec_inc >= i_seconds_per_minute) begin
                        n_second_count   = '0;
                        n_minute_pending = 1'b1;
                    end else begin
                        n_second_count = sec_inc;
                    end
                end else begin
                    n_tick_count = tick_inc;
                end
            end
            rmm_pkg::OP_SERVICE: begin
                if (r_minute_pending) begin
                    n_minute_pending = 1'b0;
                    n_minute_total   = total_inc;
                    upd0             = 1'b1;
                    if (32'(r_log_pointer) >= PAGE_BYTES) begin
                        n_log_pointer = LP_W'(rmm_pkg::WORD_BYTES);
                        cmd0  = rmm_pkg::CMD_ERASE;
                        data1 = total_inc;
                        dual  = 1'b1;
                    end else begin
                        n_log_pointer = r_log_pointer + LP_W'(rmm_pkg::WORD_BYTES);
                        cmd0  = rmm_pkg::CMD_WRITE;
                        off0  = r_log_pointer[OFF_W-1:0];
                        data0 = total_inc;
                    end
                end
            end
            rmm_pkg::OP_RESTORE: begin
                if (idx_in_page) begin
                    if (i_word_index == 7'd0) begin
                        n_restore_done = val_erased;
                        if (val_erased) begin
                            n_log_pointer  = '0;
                            n_minute_total = '0;
                            cmd0           = rmm_pkg::CMD_ERASE;
                        end else begin
                            n_minute_total = i_value;
                            n_log_pointer  = LP_W'(rmm_pkg::WORD_BYTES);
                        end
                    end else if (!r_restore_done) begin
                        if (val_erased) begin
                            n_restore_done = 1'b1;
                            n_log_pointer  = LP_W'(idx_bytes);
                        end else begin
                            n_minute_total = i_value;
                            n_log_pointer  = LP_W'(idx_next_bytes);
                        end
                    end
                end
            end
            rmm_pkg::OP_SET: begin
                n_log_pointer    = '0;
                n_minute_total   = i_value;
                n_minute_pending = 1'b1;
                cmd0             = rmm_pkg::CMD_ERASE;
            end
        endcase
    end

    assign o_push.push  = i_accept;
    assign o_push.dual  = dual;
    // {cmd, offset, data, updated, minutes, last}
    assign o_res_first  = {cmd0, off0, data0, upd0, n_minute_total, !dual};
    assign o_res_second = {cmd1, OFF_W'(0), data1, 1'b1, n_minute_total, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count     <= '0;
            r_second_count   <= rmm_pkg::SEC_RESET;
            r_minute_pending <= 1'b0;
            r_minute_total   <= '0;
            r_log_pointer    <= '0;
            r_restore_done   <= 1'b0;
        end else if (i_accept) begin
            r_tick_count     <= n_tick_count;
            r_second_count   <= n_second_count;
            r_minute_pending <= n_minute_pending;
            r_minute_total   <= n_minute_total;
            r_log_pointer    <= n_log_pointer;
            r_restore_done   <= n_restore_done;
        end
    end

    a_ptr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_log_pointer[1:0] == 2'b00)
        else $error("log pointer not word aligned");

    a_ptr_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_log_pointer) <= PAGE_BYTES)
        else $error("log pointer beyond page");

    a_set_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_opcode == rmm_pkg::OP_SET |=> r_minute_pending && r_log_pointer == '0)
        else $error("set request did not raise pending");

endmodule

// ----- design/rmm_res_fifo.sv -----
`timescale 1ns / 1ps

module rmm_res_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmm_pkg::t_push_ctl i_push,
    input  logic [WIDTH-1:0]   i_data_first,
    input  logic [WIDTH-1:0]   i_data_second,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_no_room,
    output logic [WIDTH-1:0]   o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    wr_next, wr_next2;
    logic [CW-1:0]    push_n;
    logic             pop;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign pop      = i_pop && o_valid;
    assign wr_next  = wrap_inc(r_wr);
    assign wr_next2 = wrap_inc(wr_next);
    assign push_n   = !i_push.push ? CW'(0) : (i_push.dual ? CW'(2) : CW'(1));

    always_comb begin
        n_count = r_count + push_n - CW'(pop);
        n_rd    = pop ? wrap_inc(r_rd) : r_rd;
        n_wr    = r_wr;
        if (i_push.push) begin
            n_wr = i_push.dual ? wr_next2 : wr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_data_first;
            if (i_push.dual) begin
                r_mem[wr_next] <= i_data_second;
            end
        end
    end

    assign o_valid   = r_count != '0;
    assign o_no_room = r_count > CW'(DEPTH - 2);
    assign o_data    = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> r_count <= CW'(DEPTH - 2))
        else $error("result queue push without room");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_rd == r_wr)
        else $error("empty queue with unequal pointers");

    a_dual_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push && i_push.dual && !pop |=> r_count == $past(r_count) + CW'(2))
        else $error("dual push lost an entry");

endmodule

// ----- design/runtime_minute_meter_flash_log.sv -----
`timescale 1ns / 1ps
// A request's results are registered in the result queue and offered from its head.
// One request per cycle while the input is not stalled; a service request on a full page
// gives two results, delivered in order from a four-entry result queue.
// Input stall rises while the result queue holds fewer than two free entries.
// Reset (synchronous, active low) restores the counters and registers to defaults.
module runtime_minute_meter_flash_log #(
    parameter int PAGE_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [6:0]                    i_word_index,
    input  logic [31:0]                   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_flash_cmd,
    output logic [$clog2(PAGE_BYTES)-1:0] o_byte_offset,
    output logic [31:0]                   o_write_data,
    output logic                          o_minute_updated,
    output logic [31:0]                   o_minutes,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int RES_W     = OFF_W + 68;
    localparam int QUEUE_DEP = 4;

    logic [7:0]         r_ticks_per_second;
    logic [7:0]         r_seconds_per_minute;
    logic               in_accept;
    rmm_pkg::t_push_ctl push;
    logic [RES_W-1:0]   res_first, res_second, res_head;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second   <= rmm_pkg::TPS_RESET;
            r_seconds_per_minute <= rmm_pkg::SPM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rmm_pkg::t_cfg_index'(i_cfg_index))
                rmm_pkg::CFG_TICKS_PER_SECOND:   r_ticks_per_second   <= i_cfg_data;
                rmm_pkg::CFG_SECONDS_PER_MINUTE: r_seconds_per_minute <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rmm_core #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (in_accept),
        .i_opcode            (rmm_pkg::t_opcode'(i_opcode)),
        .i_word_index        (i_word_index),
        .i_value             (i_value),
        .i_ticks_per_second  (r_ticks_per_second),
        .i_seconds_per_minute(r_seconds_per_minute),
        .o_push              (push),
        .o_res_first         (res_first),
        .o_res_second        (res_second)
    );

    rmm_res_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEP)
    ) u_res_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_first (res_first),
        .i_data_second(res_second),
        .i_pop        (!i_out_stall),
        .o_valid      (o_out_valid),
        .o_no_room    (o_in_stall),
        .o_data       (res_head)
    );

    assign {o_flash_cmd, o_byte_offset, o_write_data,
            o_minute_updated, o_minutes, o_last} = res_head;

endmodule

// ----- test/runtime_minute_meter_flash_log_tb.sv -----
`timescale 1ns / 1ps

module runtime_minute_meter_flash_log_tb;

    localparam int PAGE_BYTES   = 512;
    localparam int PAGE_WORDS   = PAGE_BYTES / rmm_pkg::WORD_BYTES;
    localparam int OFF_W        = $clog2(PAGE_BYTES);
    localparam int RANDOM_ITEMS = 1950;
    localparam int NUM_PHASES   = 7;
    localparam int QUIET_LIMIT  = 5000;
    localparam logic [7:0] PHASE_TPS [NUM_PHASES] = '{8'd2, 8'd0, 8'd1, 8'd255, 8'd3, 8'd4, 8'd1};
    localparam logic [7:0] PHASE_SPM [NUM_PHASES] = '{8'd3, 8'd0, 8'd1, 8'd255, 8'd1, 8'd2, 8'd2};

    typedef struct packed {
        rmm_pkg::t_flash_cmd cmd;
        logic [OFF_W-1:0]    off;
        logic [31:0]         data;
        logic                upd;
        logic [31:0]         mins;
        logic                fin;
    } t_meter_out;

    typedef struct {
        rmm_pkg::t_opcode op;
        logic [6:0]       idx;
        logic [31:0]      val;
        bit               typed;
        t_meter_out       want;
    } t_probe;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    opcode;
    logic [6:0]                    word_index;
    logic [31:0]                   value;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [1:0]                    flash_cmd;
    logic [OFF_W-1:0]              byte_offset;
    logic [31:0]                   write_data;
    logic                          minute_updated;
    logic [31:0]                   minutes;
    logic                          res_last;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rmm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;

    // meter mirror
    logic [7:0]  cfg_tps;
    logic [7:0]  cfg_spm;
    logic [7:0]  tick_cnt;
    logic [7:0]  sec_cnt;
    logic        minute_flag;
    logic [31:0] meter_total;
    logic [9:0]  log_ptr;
    logic        replay_ended;

    t_meter_out due_results[$];
    t_probe     directed_rows[$];
    int         mismatches = 0;
    int         sent_items = 0;
    int         quiet = 0;
    bit         calm = 1'b0;

    runtime_minute_meter_flash_log #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_word_index     (word_index),
        .i_value          (value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_flash_cmd      (flash_cmd),
        .o_byte_offset    (byte_offset),
        .o_write_data     (write_data),
        .o_minute_updated (minute_updated),
        .o_minutes        (minutes),
        .o_last           (res_last),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void queue_result(rmm_pkg::t_flash_cmd cmd, logic [OFF_W-1:0] off,
                                         logic [31:0] data, logic upd, logic fin);
        t_meter_out r;
        r.cmd  = cmd;
        r.off  = off;
        r.data = data;
        r.upd  = upd;
        r.mins = meter_total;
        r.fin  = fin;
        due_results.push_back(r);
    endfunction

    function automatic void advance_meter(rmm_pkg::t_opcode op, logic [6:0] idx,
                                          logic [31:0] val);
        case (op)
            rmm_pkg::OP_TICK: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= cfg_tps) begin
                    tick_cnt = '0;
                    sec_cnt  = sec_cnt + 8'd1;
                    if (sec_cnt >= cfg_spm) begin
                        sec_cnt     = '0;
                        minute_flag = 1'b1;
                    end
                end
                queue_result(rmm_pkg::CMD_NONE, '0, '0, 1'b0, 1'b1);
            end
            rmm_pkg::OP_SERVICE: begin
                if (!minute_flag) begin
                    queue_result(rmm_pkg::CMD_NONE, '0, '0, 1'b0, 1'b1);
                end else begin
                    minute_flag = 1'b0;
                    meter_total = meter_total + 32'd1;
                    if (log_ptr >= PAGE_BYTES) begin
                        // page full: erase, then restart at word 0
                        log_ptr = 10'(rmm_pkg::WORD_BYTES);
                        queue_result(rmm_pkg::CMD_ERASE, '0, '0, 1'b1, 1'b0);
                        queue_result(rmm_pkg::CMD_WRITE, '0, meter_total, 1'b1, 1'b1);
                    end else begin
                        queue_result(rmm_pkg::CMD_WRITE, log_ptr[OFF_W-1:0], meter_total,
                                     1'b1, 1'b1);
                        log_ptr = log_ptr + 10'(rmm_pkg::WORD_BYTES);
                    end
                end
            end
            rmm_pkg::OP_RESTORE: begin
                if (idx >= PAGE_WORDS) begin
                    queue_result(rmm_pkg::CMD_NONE, '0, '0, 1'b0, 1'b1);
                end else if (idx == 7'd0) begin
                    replay_ended = 1'b0;
                    if (val == rmm_pkg::ERASED_WORD) begin
                        replay_ended = 1'b1;
                        log_ptr      = '0;
                        meter_total  = '0;
                        queue_result(rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 1'b1);
                    end else begin
                        meter_total = val;
                        log_ptr     = 10'(rmm_pkg::WORD_BYTES);
                        queue_result(rmm_pkg::CMD_NONE, '0, '0, 1'b0, 1'b1);
                    end
                end else begin
                    if (!replay_ended) begin
                        if (val == rmm_pkg::ERASED_WORD) begin
                            replay_ended = 1'b1;
                            log_ptr      = 10'(idx * rmm_pkg::WORD_BYTES);
                        end else begin
                            meter_total = val;
                            log_ptr     = 10'((idx + 1) * rmm_pkg::WORD_BYTES);
                        end
                    end
                    queue_result(rmm_pkg::CMD_NONE, '0, '0, 1'b0, 1'b1);
                end
            end
            default: begin
                log_ptr     = '0;
                meter_total = val;
                minute_flag = 1'b1;
                queue_result(rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic t_probe mk_row(rmm_pkg::t_opcode op, logic [6:0] idx, logic [31:0] val,
                                      bit typed, rmm_pkg::t_flash_cmd cmd,
                                      logic [OFF_W-1:0] off, logic [31:0] data,
                                      logic upd, logic [31:0] mins);
        t_probe r;
        r.op        = op;
        r.idx       = idx;
        r.val       = val;
        r.typed     = typed;
        r.want.cmd  = cmd;
        r.want.off  = off;
        r.want.data = data;
        r.want.upd  = upd;
        r.want.mins = mins;
        r.want.fin  = 1'b1;
        return r;
    endfunction

    task automatic send_req(rmm_pkg::t_opcode op, logic [6:0] idx, logic [31:0] val);
        while (!calm && $urandom_range(0, 99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        word_index <= idx;
        value      <= val;
        do @(posedge clk); while (in_stall);
        advance_meter(op, idx, val);
        sent_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(rmm_pkg::t_cfg_index idx, logic [7:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rmm_pkg::CFG_TICKS_PER_SECOND) begin
            cfg_tps = data;
        end else begin
            cfg_spm = data;
        end
        @(posedge clk);
    endtask

    // replay a page image: programmed words in order, often closed by an erased word
    task automatic replay_page();
        int n;
        logic [31:0] base;
        logic [31:0] v;
        base = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            send_req(rmm_pkg::OP_RESTORE, 7'd0, rmm_pkg::ERASED_WORD);
        end else begin
            n = ($urandom_range(0, 39) == 0) ? PAGE_WORDS : $urandom_range(1, 10);
            for (int k = 0; k < n; k++) begin
                v = base + 32'(k);
                if (v == rmm_pkg::ERASED_WORD) begin
                    v = '0;
                end
                send_req(rmm_pkg::OP_RESTORE, 7'(k), v);
            end
            if (n < PAGE_WORDS && $urandom_range(0, 1) == 1) begin
                send_req(rmm_pkg::OP_RESTORE, 7'(n), rmm_pkg::ERASED_WORD);
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            send_req(rmm_pkg::OP_RESTORE, 7'($urandom_range(1, PAGE_WORDS - 1)), $urandom);
        end
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %h got %h", field, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_meter_out got;
        t_meter_out want;
        if (rst_n && out_valid && !out_stall) begin
            got.cmd  = rmm_pkg::t_flash_cmd'(flash_cmd);
            got.off  = byte_offset;
            got.data = write_data;
            got.upd  = minute_updated;
            got.mins = minutes;
            got.fin  = res_last;
            if (due_results.size() == 0) begin
                report("unexpected result, cmd", '0, 32'(got.cmd));
            end else begin
                want = due_results.pop_front();
                if (got.cmd != want.cmd) report("flash_cmd", 32'(want.cmd), 32'(got.cmd));
                if (got.off != want.off) report("byte_offset", 32'(want.off), 32'(got.off));
                if (got.data != want.data) report("write_data", want.data, got.data);
                if (got.upd != want.upd) report("minute_updated", 32'(want.upd), 32'(got.upd));
                if (got.mins != want.mins) report("minutes", want.mins, got.mins);
                if (got.fin != want.fin) report("last", 32'(want.fin), 32'(got.fin));
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < 21);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[runtime_minute_meter_flash_log] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int     pick;
        int     target;
        bit     mid_drained;
        logic [7:0] tps;
        logic [7:0] spm;
        t_probe row;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = '0;
        word_index = '0;
        value      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mid_drained = 1'b0;

        cfg_tps      = rmm_pkg::TPS_RESET;
        cfg_spm      = rmm_pkg::SPM_RESET;
        tick_cnt     = '0;
        sec_cnt      = rmm_pkg::SEC_RESET;
        minute_flag  = 1'b0;
        meter_total  = '0;
        log_ptr      = '0;
        replay_ended = 1'b0;

        directed_rows.push_back(mk_row(rmm_pkg::OP_TICK, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd127, 32'd0, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SET, 7'd0, rmm_pkg::ERASED_WORD, 1'b1,
                                       rmm_pkg::CMD_ERASE, '0, '0, 1'b0,
                                       rmm_pkg::ERASED_WORD));
        // count wraps to zero
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_WRITE, '0, 32'd0, 1'b1, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd0, rmm_pkg::ERASED_WORD, 1'b1,
                                       rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd5, 32'd123, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd0, 32'h1234_5678, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'h1234_5678));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd3, 32'hA5A5_A5A5, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'hA5A5_A5A5));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd1, 32'd7, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd7));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd2, rmm_pkg::ERASED_WORD, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd7));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd9, 32'd1, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd7));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SET, 7'd0, 32'h10, 1'b1,
                                       rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 32'h10));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd0, 32'h20, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'h20));
        directed_rows.push_back(mk_row(rmm_pkg::OP_RESTORE, 7'd127, 32'h55, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'h55));
        // full page with a minute pending: erase then write
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b0,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'h56));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SET, 7'd0, 32'h7F, 1'b1,
                                       rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 32'h7F));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_WRITE, '0, 32'h80, 1'b1, 32'h80));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SET, 7'd0, 32'hFFFF_FFFE, 1'b1,
                                       rmm_pkg::CMD_ERASE, '0, '0, 1'b0, 32'hFFFF_FFFE));
        directed_rows.push_back(mk_row(rmm_pkg::OP_SERVICE, 7'd0, 32'd0, 1'b1,
                                       rmm_pkg::CMD_WRITE, '0, rmm_pkg::ERASED_WORD, 1'b1,
                                       rmm_pkg::ERASED_WORD));
        directed_rows.push_back(mk_row(rmm_pkg::OP_TICK, 7'd0, 32'd0, 1'b0,
                                       rmm_pkg::CMD_NONE, '0, '0, 1'b0, 32'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_req(row.op, row.idx, row.val);
            if (row.typed) begin
                due_results[$] = row.want;
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            tps = PHASE_TPS[ph];
            spm = PHASE_SPM[ph];
            if (ph == 5) begin
                tps = 8'($urandom_range(1, 5));
                spm = 8'($urandom_range(0, 4));
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(rmm_pkg::CFG_TICKS_PER_SECOND, tps);
                write_reg(rmm_pkg::CFG_SECONDS_PER_MINUTE, spm);
            end else begin
                write_reg(rmm_pkg::CFG_SECONDS_PER_MINUTE, spm);
                write_reg(rmm_pkg::CFG_TICKS_PER_SECOND, tps);
            end
            calm   = (ph == 2);
            target = sent_items + RANDOM_ITEMS / NUM_PHASES;
            while (sent_items < target) begin
                if (ph == 4 && !mid_drained
                    && sent_items >= target - RANDOM_ITEMS / (2 * NUM_PHASES)) begin
                    mid_drained = 1'b1;
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_req(rmm_pkg::OP_TICK, 7'($urandom), $urandom);
                end else if (pick < 62) begin
                    send_req(rmm_pkg::OP_SERVICE, 7'($urandom), $urandom);
                end else if (pick < 70) begin
                    send_req(rmm_pkg::OP_SET, 7'($urandom), ($urandom_range(0, 3) == 0)
                             ? rmm_pkg::ERASED_WORD - 32'($urandom_range(0, 3)) : $urandom);
                end else if (pick < 88) begin
                    replay_page();
                end else begin
                    send_req(rmm_pkg::OP_RESTORE, 7'($urandom_range(0, PAGE_WORDS - 1)),
                             ($urandom_range(0, 3) == 0) ? rmm_pkg::ERASED_WORD : $urandom);
                end
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("[runtime_minute_meter_flash_log] OK");
        end else begin
            $display("[runtime_minute_meter_flash_log] ERROR");
        end
        $finish;
    end

endmodule

// ----- runtime_minute_meter_flash_log.f -----
design/rmm_pkg.sv
design/rmm_core.sv
design/rmm_res_fifo.sv
design/runtime_minute_meter_flash_log.sv
test/runtime_minute_meter_flash_log_tb.sv
